[sv/hmc_pkg.sv]
package hmc_pkg;

    localparam int AZ_W = 15;
    localparam int EL_W = 14;

    // Azimuths above a full turn are clamped to it.
    localparam logic [AZ_W-1:0] AZ_MAX = 15'd23040;

    // Operand and product widths of the interpolation compare.
    localparam int DX_W  = AZ_W + 1;
    localparam int DY_W  = EL_W + 1;
    localparam int P1_W  = EL_W + DX_W;
    localparam int P2_W  = DX_W + DY_W;
    localparam int SUM_W = P2_W + 1;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_SCMP,
        S_ICHK,
        S_QCUR,
        S_QPREV,
        S_QMUL,
        S_QCMP,
        S_SHRD,
        S_SHWR,
        S_RESP
    } t_state;

    typedef struct packed {
        logic        [AZ_W-1:0] az;
        logic signed [EL_W-1:0] el;
    } t_entry;

    typedef struct packed {
        logic        [AZ_W-1:0] az;
        logic signed [EL_W-1:0] el;
        logic        [AZ_W-1:0] x1;
        logic signed [EL_W-1:0] y1;
        logic        [AZ_W-1:0] x2;
        logic signed [EL_W-1:0] y2;
    } t_interp_req;

endpackage

[sv/hmc_if.sv]
interface hmc_in_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic        [hmc_pkg::AZ_W-1:0] azimuth;
    logic signed [hmc_pkg::EL_W-1:0] elevation;

    modport source (output valid, output mode, output azimuth, output elevation,
                    input ready);
    modport sink   (input valid, input mode, input azimuth, input elevation,
                    output ready);
endinterface

interface hmc_out_if;
    logic             valid;
    logic             ready;
    logic             visible;
    hmc_pkg::t_status status;

    modport source (output valid, output visible, output status, input ready);
    modport sink   (input valid, input visible, input status, output ready);
endinterface

[sv/hmc_interp.sv]
module hmc_interp (
    input  logic                 i_clk,
    input  hmc_pkg::t_interp_req i_req,
    output logic                 o_visible
);

    logic signed [hmc_pkg::DX_W-1:0]  dx;
    logic signed [hmc_pkg::DX_W-1:0]  daz;
    logic signed [hmc_pkg::DY_W-1:0]  dy;
    logic signed [hmc_pkg::P1_W-1:0]  n_p1;
    logic signed [hmc_pkg::P2_W-1:0]  n_p2;
    logic signed [hmc_pkg::P1_W-1:0]  n_p3;
    logic signed [hmc_pkg::P1_W-1:0]  r_p1;
    logic signed [hmc_pkg::P2_W-1:0]  r_p2;
    logic signed [hmc_pkg::P1_W-1:0]  r_p3;
    logic signed [hmc_pkg::SUM_W-1:0] lhs;
    logic signed [hmc_pkg::SUM_W-1:0] rhs;

    // The lower key is strictly below the query azimuth, so both spans are positive.
    assign dx   = $signed({1'b0, i_req.x2}) - $signed({1'b0, i_req.x1});
    assign daz  = $signed({1'b0, i_req.az}) - $signed({1'b0, i_req.x1});
    assign dy   = $signed({i_req.y2[hmc_pkg::EL_W-1], i_req.y2})
                - $signed({i_req.y1[hmc_pkg::EL_W-1], i_req.y1});
    assign n_p1 = $signed(i_req.y1) * dx;
    assign n_p2 = daz * dy;
    assign n_p3 = $signed(i_req.el) * dx;

    always_ff @(posedge i_clk) begin
        r_p1 <= n_p1;
        r_p2 <= n_p2;
        r_p3 <= n_p3;
    end

    // Mask below object: y1*dx + (az-x1)*(y2-y1) < el*dx.
    assign lhs = hmc_pkg::SUM_W'(r_p1) + hmc_pkg::SUM_W'(r_p2);
    assign rhs = hmc_pkg::SUM_W'(r_p3);
    assign o_visible = (lhs < rhs);

endmodule

[sv/horizon_mask_check_core.sv]
// Channel  Direction  Interface          Payload
// i_req    in         hmc_in_if.sink     mode, azimuth, elevation
// o_rsp    out        hmc_out_if.source  visible, status
//
// The slot search is a binary search over the point memory; each step is a read and
// then a compare. A query next reads the slot entry and, inside the span, the one
// below it for interpolation; an insert moves entries up and writes the new one.
// Reset is synchronous and clears the control state and the point count; the point
// memory is not cleared and only entries below the count are ever read.
// A finished result waits in the output register while the next transaction is
// taken; the following result holds in the response state until that register frees.
module horizon_mask_check_core #(
    parameter int MASK_POINTS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hmc_in_if.sink           i_req,
    hmc_out_if.source        o_rsp
);

    localparam int CW = $clog2(MASK_POINTS + 1);
    localparam int AW = $clog2(MASK_POINTS);

    hmc_pkg::t_entry mem [MASK_POINTS];
    hmc_pkg::t_entry r_rd_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    hmc_pkg::t_entry wr_data;

    hmc_pkg::t_state r_state, n_state;
    logic                            r_mode, n_mode;
    logic        [hmc_pkg::AZ_W-1:0] r_az, n_az;
    logic signed [hmc_pkg::EL_W-1:0] r_el, n_el;
    logic [CW-1:0]   r_lo, n_lo;
    logic [CW-1:0]   r_hi, n_hi;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_j, n_j;
    hmc_pkg::t_entry r_e1, n_e1;
    hmc_pkg::t_entry r_e2, n_e2;
    logic            r_res_vis, n_res_vis;
    hmc_pkg::t_status r_res_st, n_res_st;
    logic            r_out_valid, n_out_valid;
    logic            r_out_vis, n_out_vis;
    hmc_pkg::t_status r_out_st, n_out_st;

    logic [CW:0]     mid_sum;
    logic [CW-1:0]   mid;
    logic [CW-1:0]   cnt_m1;
    logic [CW-1:0]   lo_m1;
    logic [CW-1:0]   j_m1;
    logic            accept;
    logic            dup;
    logic [hmc_pkg::AZ_W-1:0] az_clamp;

    hmc_pkg::t_interp_req interp_req;
    logic                 interp_vis;

    hmc_interp u_interp (
        .i_clk     (i_clk),
        .i_req     (interp_req),
        .o_visible (interp_vis)
    );

    assign interp_req = '{az: r_az, el: r_el, x1: r_e1.az, y1: r_e1.el,
                          x2: r_e2.az, y2: r_e2.el};

    // Point memory: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign i_req.ready   = (r_state == hmc_pkg::S_IDLE);
    assign accept        = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.visible = r_out_vis;
    assign o_rsp.status  = r_out_st;

    assign az_clamp = (i_req.azimuth > hmc_pkg::AZ_MAX) ? hmc_pkg::AZ_MAX : i_req.azimuth;
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[CW:1];
    assign cnt_m1   = r_count - CW'(1);
    assign lo_m1    = r_lo - CW'(1);
    assign j_m1     = r_j - CW'(1);
    assign dup      = (r_lo < r_count) && (r_rd_data.az == r_az);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hmc_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_az      <= n_az;
        r_el      <= n_el;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_j       <= n_j;
        r_e1      <= n_e1;
        r_e2      <= n_e2;
        r_res_vis <= n_res_vis;
        r_res_st  <= n_res_st;
        r_out_vis <= n_out_vis;
        r_out_st  <= n_out_st;
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_az        = r_az;
        n_el        = r_el;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_count     = r_count;
        n_j         = r_j;
        n_e1        = r_e1;
        n_e2        = r_e2;
        n_res_vis   = r_res_vis;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid;
        n_out_vis   = r_out_vis;
        n_out_st    = r_out_st;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            hmc_pkg::S_IDLE: begin
                if (accept) begin
                    n_mode = i_req.mode;
                    n_az   = az_clamp;
                    n_el   = i_req.elevation;
                    n_lo   = '0;
                    n_hi   = r_count;
                    if (i_req.mode && (r_count == '0)) begin
                        n_res_vis = 1'b1;
                        n_res_st  = hmc_pkg::ST_DONE;
                        n_state   = hmc_pkg::S_RESP;
                    end else begin
                        n_state = hmc_pkg::S_SRCH;
                    end
                end
            end
            hmc_pkg::S_SRCH: begin
                if (r_lo < r_hi) begin
                    rd_en   = 1'b1;
                    rd_addr = mid[AW-1:0];
                    n_state = hmc_pkg::S_SCMP;
                end else if (r_mode) begin
                    rd_en   = 1'b1;
                    rd_addr = (r_lo >= r_count) ? cnt_m1[AW-1:0] : r_lo[AW-1:0];
                    n_state = hmc_pkg::S_QCUR;
                end else begin
                    rd_en   = (r_lo < r_count);
                    rd_addr = r_lo[AW-1:0];
                    n_state = hmc_pkg::S_ICHK;
                end
            end
            hmc_pkg::S_SCMP: begin
                if (r_rd_data.az < r_az) begin
                    n_lo = mid + CW'(1);
                end else begin
                    n_hi = mid;
                end
                n_state = hmc_pkg::S_SRCH;
            end
            hmc_pkg::S_ICHK: begin
                n_res_vis = 1'b0;
                if (dup) begin
                    n_res_st = hmc_pkg::ST_DUP;
                    n_state  = hmc_pkg::S_RESP;
                end else if (r_count >= CW'(MASK_POINTS)) begin
                    n_res_st = hmc_pkg::ST_FULL;
                    n_state  = hmc_pkg::S_RESP;
                end else begin
                    n_res_st = hmc_pkg::ST_DONE;
                    n_j      = r_count;
                    n_state  = hmc_pkg::S_SHRD;
                end
            end
            hmc_pkg::S_QCUR: begin
                n_e2     = r_rd_data;
                n_res_st = hmc_pkg::ST_DONE;
                // Outside the stored span the nearest end point sets the mask.
                if ((r_lo == '0) || (r_lo >= r_count)) begin
                    n_res_vis = ($signed(r_rd_data.el) < $signed(r_el));
                    n_state   = hmc_pkg::S_RESP;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = lo_m1[AW-1:0];
                    n_state = hmc_pkg::S_QPREV;
                end
            end
            hmc_pkg::S_QPREV: begin
                n_e1    = r_rd_data;
                n_state = hmc_pkg::S_QMUL;
            end
            hmc_pkg::S_QMUL: begin
                n_state = hmc_pkg::S_QCMP;
            end
            hmc_pkg::S_QCMP: begin
                n_res_vis = interp_vis;
                n_state   = hmc_pkg::S_RESP;
            end
            hmc_pkg::S_SHRD: begin
                if (r_j > r_lo) begin
                    rd_en   = 1'b1;
                    rd_addr = j_m1[AW-1:0];
                    n_state = hmc_pkg::S_SHWR;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_lo[AW-1:0];
                    wr_data = '{az: r_az, el: r_el};
                    n_count = r_count + CW'(1);
                    n_state = hmc_pkg::S_RESP;
                end
            end
            hmc_pkg::S_SHWR: begin
                wr_en   = 1'b1;
                wr_addr = r_j[AW-1:0];
                wr_data = r_rd_data;
                n_j     = j_m1;
                n_state = hmc_pkg::S_SHRD;
            end
            hmc_pkg::S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_vis   = r_res_vis;
                    n_out_st    = r_res_st;
                    n_state     = hmc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hmc_pkg::S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MASK_POINTS))
        else $error("point count exceeds table depth");

    a_write_in_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> ((r_state == hmc_pkg::S_SHRD) || (r_state == hmc_pkg::S_SHWR)))
        else $error("memory write outside insert shift");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == hmc_pkg::S_SRCH) || (r_state == hmc_pkg::S_SCMP))
            |-> ((r_lo <= r_hi) && (r_hi <= r_count)))
        else $error("search window out of range");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hmc_pkg::S_IDLE) |=> (r_count == $past(r_count)))
        else $error("point count changed while idle");
`endif

endmodule

[tb/sv/tb_horizon_mask_check_core.sv]
`timescale 1ns / 1ps

module tb_horizon_mask_check_core;

    localparam int  MASK_POINTS  = 64;
    localparam int  LIMIT_CYCLES = 1000000;
    localparam int  IDLE_PCT     = 16;
    localparam bit  MODE_INSERT  = 1'b0;
    localparam bit  MODE_QUERY   = 1'b1;

    typedef struct {
        bit               visible;
        hmc_pkg::t_status status;
    } t_mask_answer;

    // Tracks the horizon mask as the block should hold it and the answers it owes.
    class mask_scoreboard;
        int unsigned                     n_points;
        logic [hmc_pkg::AZ_W-1:0]        pt_az[MASK_POINTS];
        logic signed [hmc_pkg::EL_W-1:0] pt_el[MASK_POINTS];
        t_mask_answer                    answer_q[$];
        int                              errors;

        function new();
            n_points = 0;
            errors   = 0;
        endfunction

        function int pending();
            return answer_q.size();
        endfunction

        function int unsigned slot_of(logic [hmc_pkg::AZ_W-1:0] az);
            int unsigned i;
            i = 0;
            while (i < n_points && pt_az[i] < az) i++;
            return i;
        endfunction

        function void note_request(bit mode, logic [hmc_pkg::AZ_W-1:0] az_in,
                                   logic signed [hmc_pkg::EL_W-1:0] el);
            t_mask_answer             ans;
            logic [hmc_pkg::AZ_W-1:0] az;
            int unsigned              i;
            longint                   x1, x2, y1, y2, azl, lhs, rhs;
            az = (az_in > hmc_pkg::AZ_MAX) ? hmc_pkg::AZ_MAX : az_in;
            i = slot_of(az);
            ans.visible = 1'b0;
            ans.status  = hmc_pkg::ST_DONE;
            if (mode == MODE_QUERY) begin
                if (n_points == 0) begin
                    ans.visible = 1'b1;
                end else if (i >= n_points) begin
                    ans.visible = pt_el[n_points-1] < el;
                end else if (i == 0) begin
                    ans.visible = pt_el[0] < el;
                end else begin
                    x1  = pt_az[i-1];
                    x2  = pt_az[i];
                    y1  = pt_el[i-1];
                    y2  = pt_el[i];
                    azl = az;
                    lhs = y1 * (x2 - x1) + (azl - x1) * (y2 - y1);
                    rhs = el;
                    rhs = rhs * (x2 - x1);
                    ans.visible = lhs < rhs;
                end
            end else if (i < n_points && pt_az[i] == az) begin
                ans.status = hmc_pkg::ST_DUP;
            end else if (n_points >= MASK_POINTS) begin
                ans.status = hmc_pkg::ST_FULL;
            end else begin
                for (int j = n_points; j > i; j--) begin
                    pt_az[j] = pt_az[j-1];
                    pt_el[j] = pt_el[j-1];
                end
                pt_az[i] = az;
                pt_el[i] = el;
                n_points++;
            end
            answer_q.push_back(ans);
        endfunction

        function void check_response(bit visible, hmc_pkg::t_status status);
            t_mask_answer ans;
            if (answer_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result visible %0b status %0d", $time,
                         visible, status);
                return;
            end
            ans = answer_q.pop_front();
            if (ans.visible !== visible) begin
                errors++;
                $display("%0t: visible mismatch, expected %0b actual %0b", $time,
                         ans.visible, visible);
            end
            if (ans.status !== status) begin
                errors++;
                $display("%0t: status mismatch, expected %0d actual %0d", $time,
                         ans.status, status);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    hmc_in_if  req_if();
    hmc_out_if rsp_if();

    mask_scoreboard sb;
    bit             idle_on;
    int             hold_left;
    int             cycle_count;

    horizon_mask_check_core #(
        .MASK_POINTS(MASK_POINTS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("horizon_mask_check_core regression: fail");
        $finish;
    end

    // Result side: checks every transaction and drives ready, with an optional long hold.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready)
                sb.check_response(rsp_if.visible, rsp_if.status);
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic send_item(bit mode, logic [hmc_pkg::AZ_W-1:0] az,
                             logic signed [hmc_pkg::EL_W-1:0] el);
        if (idle_on) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_if.valid     <= 1'b1;
        req_if.mode      <= mode;
        req_if.azimuth   <= az;
        req_if.elevation <= el;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(mode, az, el);
    endtask

    task automatic wait_all_answered();
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_item();
        int                              pick;
        int unsigned                     k;
        int                              az;
        longint                          x1, x2, y1, y2, ev;
        logic signed [hmc_pkg::EL_W-1:0] el;
        bit                              mode;
        pick = $urandom_range(99);
        mode = MODE_QUERY;
        az   = $urandom_range(32767);
        el   = hmc_pkg::EL_W'($urandom());
        if (pick < 28 && (pick < 20 || sb.n_points == 0)) begin
            // Fresh point; once the table is full these come back as dropped.
            mode = MODE_INSERT;
            if ($urandom_range(9) != 0) begin
                az = $urandom_range(23040);
                el = hmc_pkg::EL_W'(int'($urandom_range(11520)) - 5760);
            end
        end else if (pick < 28) begin
            mode = MODE_INSERT;
            az   = sb.pt_az[$urandom_range(sb.n_points - 1)];
        end else if (pick < 60 && sb.n_points >= 2) begin
            // Aim the object just around the interpolated mask line.
            k  = $urandom_range(sb.n_points - 1, 1);
            x1 = sb.pt_az[k-1];
            x2 = sb.pt_az[k];
            y1 = sb.pt_el[k-1];
            y2 = sb.pt_el[k];
            az = $urandom_range(x2, x1);
            ev = y1 + ((az - x1) * (y2 - y1)) / (x2 - x1) + int'($urandom_range(2)) - 1;
            if (ev > 8191) ev = 8191;
            if (ev < -8192) ev = -8192;
            el = hmc_pkg::EL_W'(ev);
        end else if (pick < 75 && sb.n_points >= 1) begin
            k  = $urandom_range(sb.n_points - 1);
            az = int'(sb.pt_az[k]) + int'($urandom_range(2)) - 1;
            if (az < 0) az = 0;
            el = sb.pt_el[k] + hmc_pkg::EL_W'(int'($urandom_range(2)) - 1);
        end
        send_item(mode, hmc_pkg::AZ_W'(az), el);
    endtask

    initial begin
        sb               = new();
        idle_on          = 1'b1;
        hold_left        = 0;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.mode      = MODE_INSERT;
        req_if.azimuth   = '0;
        req_if.elevation = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(MODE_QUERY,  15'd0,     -14'sd8192);
        send_item(MODE_QUERY,  15'd32767, 14'sd8191);
        send_item(MODE_INSERT, 15'd5760,  14'sd100);
        send_item(MODE_INSERT, 15'd5760,  14'sd50);
        send_item(MODE_QUERY,  15'd0,     14'sd100);
        send_item(MODE_QUERY,  15'd5760,  14'sd101);
        send_item(MODE_QUERY,  15'd32767, 14'sd99);
        send_item(MODE_INSERT, 15'd17280, -14'sd200);
        send_item(MODE_QUERY,  15'd11520, -14'sd50);
        send_item(MODE_QUERY,  15'd11520, -14'sd49);
        send_item(MODE_QUERY,  15'd17280, -14'sd199);
        send_item(MODE_INSERT, 15'd32767, 14'sd8191);
        send_item(MODE_INSERT, 15'd23040, 14'sd0);
        send_item(MODE_INSERT, 15'd0,     -14'sd8192);
        send_item(MODE_QUERY,  15'd0,     -14'sd8191);
        send_item(MODE_QUERY,  15'd23041, 14'sd8191);
        send_item(MODE_INSERT, 15'd11520, 14'sd5760);
        send_item(MODE_QUERY,  15'd11520, 14'sd5760);
        send_item(MODE_QUERY,  15'd11521, 14'sd5760);
        send_item(MODE_INSERT, 15'd20000, -14'sd5760);
        send_item(MODE_QUERY,  15'd21000, 14'sd8191);
        send_item(MODE_QUERY,  15'd16384, -14'sd1);

        repeat (300) send_random_item();
        wait_all_answered();

        // Hold the result side off long enough for the block to back up its input.
        hold_left = 400;
        repeat (40) send_random_item();

        idle_on = 1'b0;
        repeat (250) send_random_item();
        idle_on = 1'b1;
        wait_all_answered();
        repeat (490) send_random_item();

        wait_all_answered();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("horizon_mask_check_core regression: pass");
        end else begin
            $display("horizon_mask_check_core regression: fail");
        end
        $finish;
    end

endmodule
